// ===== hw/rtl/pcd_pkg.sv =====
// Package for the PID controller block: field widths, register indexes,
// sequencer states and the 48-bit saturation helper.
// No dependencies; compiled first.
`default_nettype none

package pcd_pkg;

  localparam int SampleW = 16;
  localparam int ErrW    = 17;
  localparam int GainW   = 24;
  localparam int LimW    = 31;
  localparam int BandW   = 16;
  localparam int ModeW   = 2;
  localparam int DriveW  = 32;
  localparam int AccW    = 48;
  localparam int MulAW   = 33;
  localparam int MulBW   = 25;
  localparam int ProdW   = MulAW + MulBW;
  localparam int SumW    = 64;
  localparam int AddrW   = 5;
  localparam int DataW   = 32;

  localparam int ModeIncrBit = 0;
  localparam int ModeTrapBit = 1;

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_INTEG_LIMIT = 3'd3,
    REG_OUT_LIMIT   = 3'd4,
    REG_INTEG_BAND  = 3'd5,
    REG_DEAD_ZONE   = 3'd6,
    REG_CTRL_MODE   = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROP,
    ST_QEST,
    ST_QFIX,
    ST_COEF,
    ST_INT_LO,
    ST_INT_HI,
    ST_DER,
    ST_DER_LO,
    ST_DER_HI,
    ST_FLT_LO,
    ST_FLT_HI,
    ST_DSAT,
    ST_SUM,
    ST_OUT
  } seq_state_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  function automatic logic signed [AccW-1:0] sat_acc(input logic signed [SumW-1:0] x);
    logic signed [AccW-1:0] res;
    if (x > SumW'(AccMax)) begin
      res = AccMax;
    end else if (x < SumW'(AccMin)) begin
      res = AccMin;
    end else begin
      res = AccW'(x);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pcd_ifs.sv =====
// Valid/ready channel interfaces for the PID controller block.
// Depends on pcd_pkg for the field widths.
`default_nettype none

interface pcd_in_if;
  import pcd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] setpoint;
  logic signed [SampleW-1:0] measurement;
  modport source (output valid, setpoint, measurement, input ready);
  modport sink (input valid, setpoint, measurement, output ready);
endinterface

interface pcd_out_if;
  import pcd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DriveW-1:0] drive;
  logic                     in_dead_zone;
  logic                     saturated;
  modport source (output valid, drive, in_dead_zone, saturated, input ready);
  modport sink (input valid, drive, in_dead_zone, saturated, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pid_controller_pos_delta_top.sv =====
// PID controller, positional or incremental form, in fixed point.
// Input words carry a setpoint and a measurement; each result word carries
// the clamped drive and two status flags. Eight gain, limit and mode
// registers are written through an APB-style port at byte address 4*index.
// One signed 33x25 multiplier with a 64-bit accumulator does all products,
// stepped by a sequencer; the block takes one input word at a time.
// An accepted word passes through the sequencer steps to the result register,
// and the block returns to idle before it accepts the next word. A dead-zone
// word goes from the proportional step straight to the output step.
// The sequence is made of the eleven multiplier steps plus the saturation,
// summing and output steps, and the idle step that takes a word.
// The result sits in an output register; while the receiver stalls, the
// block still accepts and computes the next word, then waits in its final
// step until the register is free.
// Synchronous reset clears the controller history and sets the registers
// to their reset values; no result is pending after reset.
// Depends on pcd_pkg and the channel interfaces in pcd_ifs.
`default_nettype none

module pid_controller_pos_delta_top #(
  parameter int DERIV_FILTER_Q15 = 0,
  parameter int VARINT_LOW       = 1024,
  parameter int VARINT_HIGH      = 4096
) (
  input  logic                      clk,
  input  logic                      rst_n,
  pcd_in_if.sink                    in_ch,
  pcd_out_if.source                 out_ch,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pcd_pkg::AddrW-1:0] paddr,
  input  logic [pcd_pkg::DataW-1:0] pwdata,
  output logic [pcd_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import pcd_pkg::*;

  localparam longint VarSpan   = longint'(VARINT_HIGH) - longint'(VARINT_LOW);
  localparam longint RecipFull = (VarSpan > 0) ? (64'sd4294967296 / VarSpan) : 64'sd0;
  localparam longint RecipCap  = (RecipFull > 64'sd4294967295) ? 64'sd4294967295 : RecipFull;
  localparam logic [31:0] Recip = 32'(RecipCap);
  localparam logic [15:0] SpanK = 16'(VarSpan);
  localparam logic [15:0] FiltK = 16'(DERIV_FILTER_Q15 & 32'h7FFF);
  localparam logic [15:0] FiltC = 16'(32768 - (DERIV_FILTER_Q15 & 32'h7FFF));
  localparam logic [16:0] VarLo = 17'(VARINT_LOW);
  localparam logic [16:0] VarHi = 17'(VARINT_HIGH);
  localparam int SumOW = 50;
  localparam int PW    = 41;
  localparam int CvW   = 34;
  localparam int KddW  = 43;

  // Configuration registers.
  logic signed [GainW-1:0] kp_r, ki_r, kd_r;
  logic [LimW-1:0]         ilim_r, olim_r;
  logic [BandW-1:0]        band_r, dzl_r;
  logic [ModeW-1:0]        mode_r;

  // Sequencer and controller history.
  seq_state_t              state_r, state_nxt;
  logic signed [ErrW-1:0]  e_r, e_nxt, pe_r, pe_nxt, ppe_r, ppe_nxt;
  logic signed [DriveW-1:0] iacc_r, iacc_nxt;
  logic signed [AccW-1:0]  oacc_r, oacc_nxt, h1_r, h1_nxt, h2_r, h2_nxt;

  // Intermediate results.
  logic signed [PW-1:0]     p_r, p_nxt;
  logic [15:0]              q_r, q_nxt;
  logic signed [CvW-1:0]    cv_r, cv_nxt;
  logic signed [KddW-1:0]   kdd_r, kdd_nxt;
  logic signed [SumW-1:0]   acc_r, acc_nxt;
  logic signed [DriveW-1:0] integ_r, integ_nxt;
  logic signed [AccW-1:0]   d_r, d_nxt;
  logic                     dz_r, dz_nxt;

  // Output register.
  logic                     ov_r, ov_nxt;
  logic signed [DriveW-1:0] odrive_r, odrive_nxt;
  logic                     odz_r, odz_nxt, osat_r, osat_nxt;

  // Sequencer outputs.
  logic                     in_ready;
  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  acc_op_t                  acc_op;
  logic [4:0]               acc_sh;

  logic signed [ProdW-1:0]  prod;
  logic signed [SumW-1:0]   acc_term;

  logic [ErrW-1:0]          ae;
  logic                     dz_hit, in_band, incr, trap, allow, out_free;
  logic signed [AccW-1:0]   olim_s, ilim_s, hist;
  logic signed [AccW:0]     hdiff;
  logic signed [17:0]       pdiff, esum;
  logic signed [18:0]       diff;
  logic [15:0]              m16;
  logic [16:0]              coef;
  logic signed [33:0]       rem;
  logic signed [AccW-1:0]   inc_sel, inc, integ_pre;
  logic signed [SumOW-1:0]  sum;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= '0;
      ki_r   <= '0;
      kd_r   <= '0;
      ilim_r <= '1;
      olim_r <= '1;
      band_r <= '1;
      dzl_r  <= '0;
      mode_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_PROP_GAIN:   kp_r   <= pwdata[GainW-1:0];
        REG_INTEG_GAIN:  ki_r   <= pwdata[GainW-1:0];
        REG_DERIV_GAIN:  kd_r   <= pwdata[GainW-1:0];
        REG_INTEG_LIMIT: ilim_r <= pwdata[LimW-1:0];
        REG_OUT_LIMIT:   olim_r <= pwdata[LimW-1:0];
        REG_INTEG_BAND:  band_r <= pwdata[BandW-1:0];
        REG_DEAD_ZONE:   dzl_r  <= pwdata[BandW-1:0];
        REG_CTRL_MODE:   mode_r <= pwdata[ModeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_PROP_GAIN:   prdata = {8'b0, kp_r};
      REG_INTEG_GAIN:  prdata = {8'b0, ki_r};
      REG_DERIV_GAIN:  prdata = {8'b0, kd_r};
      REG_INTEG_LIMIT: prdata = {1'b0, ilim_r};
      REG_OUT_LIMIT:   prdata = {1'b0, olim_r};
      REG_INTEG_BAND:  prdata = {16'b0, band_r};
      REG_DEAD_ZONE:   prdata = {16'b0, dzl_r};
      REG_CTRL_MODE:   prdata = {30'b0, mode_r};
      default:         prdata = '0;
    endcase
  end

  // Error-derived terms.
  assign ae      = e_r[ErrW-1] ? ErrW'(-e_r) : ErrW'(e_r);
  assign dz_hit  = ae < {1'b0, dzl_r};
  assign in_band = ae < {1'b0, band_r};
  assign incr    = mode_r[ModeIncrBit];
  assign trap    = mode_r[ModeTrapBit];
  assign olim_s  = $signed({17'b0, olim_r});
  assign ilim_s  = $signed({17'b0, ilim_r});
  assign allow   = (oacc_r <= olim_s) || e_r[ErrW-1];
  assign pdiff   = incr ? (18'(e_r) - 18'(pe_r)) : 18'(e_r);
  assign esum    = trap ? (18'(e_r) + 18'(pe_r)) : 18'(e_r);
  assign diff    = incr ? (19'(e_r) - (19'(pe_r) <<< 1) + 19'(ppe_r))
                        : (19'(e_r) - 19'(pe_r));
  assign hdiff   = (AccW+1)'(h1_r) - (AccW+1)'(h2_r);
  assign hist    = incr ? sat_acc(SumW'(hdiff)) : h1_r;
  assign m16     = 16'(VarHi - ae);
  assign out_free = !ov_r || out_ch.ready;

  always_comb begin
    if (ae <= VarLo) begin
      coef = 17'h10000;
    end else if (ae > VarHi) begin
      coef = '0;
    end else begin
      coef = {1'b0, q_r};
    end
  end

  // Shared multiplier and accumulator term.
  assign prod = ProdW'(mul_a) * ProdW'(mul_b);
  assign acc_term = SumW'(prod) <<< acc_sh;

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_ch.valid) state_nxt = ST_PROP;
      ST_PROP:   state_nxt = dz_hit ? ST_OUT : ST_QEST;
      ST_QEST:   state_nxt = ST_QFIX;
      ST_QFIX:   state_nxt = ST_COEF;
      ST_COEF:   state_nxt = ST_INT_LO;
      ST_INT_LO: state_nxt = ST_INT_HI;
      ST_INT_HI: state_nxt = ST_DER;
      ST_DER:    state_nxt = ST_DER_LO;
      ST_DER_LO: state_nxt = ST_DER_HI;
      ST_DER_HI: state_nxt = ST_FLT_LO;
      ST_FLT_LO: state_nxt = ST_FLT_HI;
      ST_FLT_HI: state_nxt = ST_DSAT;
      ST_DSAT:   state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_OUT;
      ST_OUT:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer: multiplier operands and accumulator control.
  always_comb begin
    in_ready = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    acc_op   = ACC_HOLD;
    acc_sh   = 5'd0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_PROP: begin
        mul_a = MulAW'(pdiff);
        mul_b = MulBW'(kp_r);
      end
      ST_QEST: begin
        mul_a = $signed({1'b0, Recip});
        mul_b = $signed({9'b0, m16});
      end
      ST_QFIX: begin
        mul_a = $signed({17'b0, q_r});
        mul_b = $signed({9'b0, SpanK});
      end
      ST_COEF: begin
        mul_a = MulAW'(esum);
        mul_b = $signed({8'b0, coef});
      end
      ST_INT_LO: begin
        mul_a  = $signed({16'b0, cv_r[16:0]});
        mul_b  = MulBW'(ki_r);
        acc_op = ACC_LOAD;
      end
      ST_INT_HI: begin
        mul_a  = MulAW'($signed(cv_r[CvW-1:17]));
        mul_b  = MulBW'(ki_r);
        acc_op = ACC_ADD;
        acc_sh = 5'd17;
      end
      ST_DER: begin
        mul_a = MulAW'(diff);
        mul_b = MulBW'(kd_r);
      end
      ST_DER_LO: begin
        mul_a  = $signed({9'b0, kdd_r[23:0]});
        mul_b  = $signed({9'b0, FiltC});
        acc_op = ACC_LOAD;
      end
      ST_DER_HI: begin
        mul_a  = MulAW'($signed(kdd_r[KddW-1:24]));
        mul_b  = $signed({9'b0, FiltC});
        acc_op = ACC_ADD;
        acc_sh = 5'd24;
      end
      ST_FLT_LO: begin
        mul_a  = $signed({9'b0, hist[23:0]});
        mul_b  = $signed({9'b0, FiltK});
        acc_op = ACC_ADD;
      end
      ST_FLT_HI: begin
        mul_a  = MulAW'($signed(hist[AccW-1:24]));
        mul_b  = $signed({9'b0, FiltK});
        acc_op = ACC_ADD;
        acc_sh = 5'd24;
      end
      default: ;
    endcase
  end

  assign in_ch.ready = in_ready;

  // Integral update from the accumulated Ki*coef*esum product.
  always_comb begin
    inc_sel = trap ? AccW'(acc_r >>> 17) : AccW'(acc_r >>> 16);
    inc     = allow ? inc_sel : '0;
    if (!in_band) begin
      integ_pre = '0;
    end else if (incr) begin
      integ_pre = inc;
    end else begin
      integ_pre = AccW'(iacc_r) + inc;
    end
  end

  assign rem = $signed({2'b0, m16, 16'b0}) - CvW'(prod);
  assign sum = (incr ? SumOW'(oacc_r) : SumOW'(0)) + SumOW'(p_r) + SumOW'(integ_r)
             + SumOW'(d_r);

  // Datapath next values.
  always_comb begin
    e_nxt      = e_r;
    pe_nxt     = pe_r;
    ppe_nxt    = ppe_r;
    iacc_nxt   = iacc_r;
    oacc_nxt   = oacc_r;
    h1_nxt     = h1_r;
    h2_nxt     = h2_r;
    p_nxt      = p_r;
    q_nxt      = q_r;
    cv_nxt     = cv_r;
    kdd_nxt    = kdd_r;
    integ_nxt  = integ_r;
    d_nxt      = d_r;
    dz_nxt     = dz_r;
    ov_nxt     = ov_r && !out_ch.ready;
    odrive_nxt = odrive_r;
    odz_nxt    = odz_r;
    osat_nxt   = osat_r;
    case (acc_op)
      ACC_LOAD: acc_nxt = acc_term;
      ACC_ADD:  acc_nxt = acc_r + acc_term;
      default:  acc_nxt = acc_r;
    endcase
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          e_nxt = ErrW'(in_ch.setpoint) - ErrW'(in_ch.measurement);
        end
      end
      ST_PROP: begin
        dz_nxt = dz_hit;
        p_nxt  = PW'(prod);
        if (dz_hit) begin
          pe_nxt   = '0;
          ppe_nxt  = '0;
          iacc_nxt = '0;
          oacc_nxt = '0;
          h1_nxt   = '0;
          h2_nxt   = '0;
        end
      end
      ST_QEST: q_nxt = prod[31:16];
      ST_QFIX: begin
        if (rem >= $signed({18'b0, SpanK})) begin
          q_nxt = q_r + 16'd1;
        end
      end
      ST_COEF: cv_nxt = CvW'(prod);
      ST_DER: begin
        kdd_nxt = KddW'(prod);
        if (integ_pre > ilim_s) begin
          integ_nxt = DriveW'(ilim_s);
        end else if (integ_pre < -ilim_s) begin
          integ_nxt = DriveW'(-ilim_s);
        end else begin
          integ_nxt = DriveW'(integ_pre);
        end
      end
      ST_DSAT: d_nxt = sat_acc(acc_r >>> 15);
      ST_SUM: begin
        oacc_nxt = sat_acc(SumW'(sum));
        iacc_nxt = integ_r;
        if (incr) begin
          ppe_nxt = pe_r;
        end
        pe_nxt = e_r;
        h2_nxt = h1_r;
        h1_nxt = d_r;
      end
      ST_OUT: begin
        if (out_free) begin
          ov_nxt  = 1'b1;
          odz_nxt = dz_r;
          if (oacc_r > olim_s) begin
            odrive_nxt = DriveW'(olim_s);
            osat_nxt   = 1'b1;
          end else if (oacc_r < -olim_s) begin
            odrive_nxt = DriveW'(-olim_s);
            osat_nxt   = 1'b1;
          end else begin
            odrive_nxt = DriveW'(oacc_r);
            osat_nxt   = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pe_r    <= '0;
      ppe_r   <= '0;
      iacc_r  <= '0;
      oacc_r  <= '0;
      h1_r    <= '0;
      h2_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pe_r    <= pe_nxt;
      ppe_r   <= ppe_nxt;
      iacc_r  <= iacc_nxt;
      oacc_r  <= oacc_nxt;
      h1_r    <= h1_nxt;
      h2_r    <= h2_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r      <= e_nxt;
    p_r      <= p_nxt;
    q_r      <= q_nxt;
    cv_r     <= cv_nxt;
    kdd_r    <= kdd_nxt;
    acc_r    <= acc_nxt;
    integ_r  <= integ_nxt;
    d_r      <= d_nxt;
    dz_r     <= dz_nxt;
    odrive_r <= odrive_nxt;
    odz_r    <= odz_nxt;
    osat_r   <= osat_nxt;
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.drive        = odrive_r;
  assign out_ch.in_dead_zone = odz_r;
  assign out_ch.saturated    = osat_r;

  // An accepted word always starts the multiply sequence.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == ST_PROP)
    else $error("accepted word did not start the sequence");

  // A dead-zone word wipes the controller history.
  a_dz_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PROP && dz_hit |=> oacc_r == '0 && pe_r == '0 && h1_r == '0)
    else $error("dead zone left history behind");

  // A dead-zone result carries zero drive and no saturation flag.
  a_dz_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.in_dead_zone |-> out_ch.drive == '0 && !out_ch.saturated)
    else $error("dead-zone result is not zero");

  // A pending result always lies within the output clamp.
  a_drive_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.drive <= $signed({1'b0, olim_r}))
                  && (out_ch.drive >= -$signed({1'b0, olim_r})))
    else $error("drive outside the output limit");

  // The result register is only loaded from the final sequencer step.
  a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(state_r == ST_OUT))
    else $error("result loaded outside the output step");

endmodule

`default_nettype wire

// ===== verif/pid_controller_pos_delta_top_test.sv =====
// Self-checking testbench for pid_controller_pos_delta_top: directed ticks, then random
// ticks under random register settings, checked against an in-bench PID predictor.
// Depends on pcd_pkg, the channel interfaces in pcd_ifs and the block itself.
`timescale 1ns / 100ps

module pid_controller_pos_delta_top_test;
  import pcd_pkg::*;

  localparam int VarintLow  = 1024;
  localparam int VarintHigh = 4096;
  localparam int FilterQ15  = 0;

  localparam int CycleLimit    = 600000;
  localparam int RandPhases    = 12;
  localparam int WordsPerPhase = 150;
  localparam int NumDir        = 24;

  localparam logic [ModeW-1:0] ModePos      = 2'd0;
  localparam logic [ModeW-1:0] ModeIncr     = 2'd1;
  localparam logic [ModeW-1:0] ModeTrap     = 2'd2;
  localparam logic [ModeW-1:0] ModeIncrTrap = 2'd3;

  localparam longint S48Max = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint S48Min = -S48Max - 1;

  localparam logic signed [DriveW-1:0] DirLim = 32'sd65536000;

  typedef struct packed {
    logic signed [GainW-1:0] kp;
    logic signed [GainW-1:0] ki;
    logic signed [GainW-1:0] kd;
    logic [LimW-1:0]         ilim;
    logic [LimW-1:0]         olim;
    logic [BandW-1:0]        band;
    logic [BandW-1:0]        dz;
    logic [ModeW-1:0]        mode;
  } pid_cfg_t;

  typedef struct packed {
    logic signed [DriveW-1:0] drive;
    logic                     dz;
    logic                     sat;
  } pid_result_t;

  typedef struct packed {
    logic [2:0]                group;
    logic signed [SampleW-1:0] sp;
    logic signed [SampleW-1:0] ms;
    logic                      known;
    logic signed [DriveW-1:0]  drive;
    logic                      dz;
    logic                      sat;
  } dir_row_t;

  dir_row_t dir_rows [NumDir] = '{
    '{3'd0, 16'sh7fff, 16'sh8000, 1'b1, 32'sd0, 1'b0, 1'b0},
    '{3'd0, 16'sh8000, 16'sh7fff, 1'b1, 32'sd0, 1'b0, 1'b0},
    '{3'd0, 16'sd0, 16'sd0, 1'b1, 32'sd0, 1'b0, 1'b0},
    '{3'd1, 16'sd10, 16'sd0, 1'b1, 32'sd0, 1'b1, 1'b0},
    '{3'd1, 16'sh7fff, 16'sh8000, 1'b1, DirLim, 1'b0, 1'b1},
    '{3'd1, 16'sh8000, 16'sh7fff, 1'b1, -DirLim, 1'b0, 1'b1},
    '{3'd1, 16'sd50, 16'sd0, 1'b0, 32'sd0, 1'b0, 1'b0},
    '{3'd1, 16'sd1024, 16'sd0, 1'b0, 32'sd0, 1'b0, 1'b0},
    '{3'd1, 16'sd1025, 16'sd0, 1'b0, 32'sd0, 1'b0, 1'b0},
    '{3'd1, 16'sd0, 16'sd4096, 1'b0, 32'sd0, 1'b0, 1'b0},
    '{3'd1, 16'sd4097, 16'sd0, 1'b0, 32'sd0, 1'b0, 1'b0},
    '{3'd2, 16'sd100, 16'sd0, 1'b0, 32'sd0, 1'b0, 1'b0},
    '{3'd2, 16'sd1500, -16'sd500, 1'b0, 32'sd0, 1'b0, 1'b0},
    '{3'd2, 16'sd1999, 16'sd0, 1'b0, 32'sd0, 1'b0, 1'b0},
    '{3'd2, -16'sd3000, 16'sd0, 1'b0, 32'sd0, 1'b0, 1'b0},
    '{3'd2, 16'sh8000, 16'sh7fff, 1'b0, 32'sd0, 1'b0, 1'b0},
    '{3'd3, 16'sd50, 16'sd0, 1'b0, 32'sd0, 1'b0, 1'b0},
    '{3'd3, 16'sd50, 16'sd0, 1'b0, 32'sd0, 1'b0, 1'b0},
    '{3'd3, 16'sd50, 16'sd0, 1'b0, 32'sd0, 1'b0, 1'b0},
    '{3'd3, -16'sd50, 16'sd0, 1'b0, 32'sd0, 1'b0, 1'b0},
    '{3'd3, 16'sd50, 16'sd0, 1'b0, 32'sd0, 1'b0, 1'b0},
    '{3'd4, 16'sd0, 16'sd0, 1'b1, 32'sd0, 1'b1, 1'b0},
    '{3'd4, 16'sh7fff, 16'sh8000, 1'b1, 32'sd0, 1'b0, 1'b1},
    '{3'd4, 16'sh8000, 16'sh7fff, 1'b0, 32'sd0, 1'b0, 1'b0}
  };

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic pready;

  pcd_in_if in_ch ();
  pcd_out_if out_ch ();

  pid_controller_pos_delta_top #(
    .DERIV_FILTER_Q15(FilterQ15),
    .VARINT_LOW(VarintLow),
    .VARINT_HIGH(VarintHigh)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  pid_cfg_t settings;
  longint last_err;
  longint last_err2;
  longint integ_state;
  longint out_state;
  longint deriv_last;
  longint deriv_last2;

  pid_result_t pending_drives [$];
  bit quiet;
  int error_count;
  int words_sent;
  int words_checked;
  int dz_seen;
  int sat_seen;
  int settings_count;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d words outstanding", cycles,
               pending_drives.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    error_count++;
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
  endtask

  function automatic longint clip48(input longint x);
    if (x > S48Max) begin
      return S48Max;
    end
    if (x < S48Min) begin
      return S48Min;
    end
    return x;
  endfunction

  function automatic longint clip_sym(input longint x, input longint lim);
    if (x > lim) begin
      return lim;
    end
    if (x < -lim) begin
      return -lim;
    end
    return x;
  endfunction

  function automatic pid_result_t predict_tick(input logic signed [SampleW-1:0] sp,
                                               input logic signed [SampleW-1:0] ms);
    pid_result_t r;
    longint e, ae, kp, ki, kd, lim_i, lim_o, p, integ, inc, coef, diff, hist, d, drv;
    bit incr, trap, allow;
    e = longint'(sp) - longint'(ms);
    ae = (e < 0) ? -e : e;
    incr = settings.mode[ModeIncrBit];
    trap = settings.mode[ModeTrapBit];
    kp = longint'(settings.kp);
    ki = longint'(settings.ki);
    kd = longint'(settings.kd);
    lim_i = longint'(settings.ilim);
    lim_o = longint'(settings.olim);
    if (ae < longint'(settings.dz)) begin
      last_err = 0;
      last_err2 = 0;
      integ_state = 0;
      out_state = 0;
      deriv_last = 0;
      deriv_last2 = 0;
      r.drive = '0;
      r.dz = 1'b1;
      r.sat = 1'b0;
      return r;
    end
    p = incr ? kp * (e - last_err) : kp * e;
    if (ae < longint'(settings.band)) begin
      allow = !(out_state > lim_o) || (e < 0);
      if (ae <= VarintLow) begin
        coef = 65536;
      end else if (ae > VarintHigh || VarintHigh <= VarintLow) begin
        coef = 0;
      end else begin
        coef = ((longint'(VarintHigh) - ae) * 65536) / longint'(VarintHigh - VarintLow);
      end
      inc = 0;
      if (allow) begin
        inc = trap ? (ki * (e + last_err) * coef) >>> 17 : (ki * e * coef) >>> 16;
      end
      if (incr) begin
        integ = inc;
      end else begin
        integ = allow ? integ_state + inc : integ_state;
      end
    end else begin
      integ = 0;
    end
    integ = clip_sym(integ, lim_i);
    if (incr) begin
      diff = e - 2 * last_err + last_err2;
      hist = clip48(deriv_last - deriv_last2);
    end else begin
      diff = e - last_err;
      hist = deriv_last;
    end
    d = clip48((kd * diff * (32768 - FilterQ15) + longint'(FilterQ15) * hist) >>> 15);
    out_state = incr ? clip48(out_state + p + integ + d) : clip48(p + integ + d);
    integ_state = integ;
    if (incr) begin
      last_err2 = last_err;
    end
    last_err = e;
    deriv_last2 = deriv_last;
    deriv_last = d;
    drv = clip_sym(out_state, lim_o);
    r.drive = drv[DriveW-1:0];
    r.dz = 1'b0;
    r.sat = (drv != out_state);
    return r;
  endfunction

  task automatic apb_write(input reg_idx_t idx, input logic [DataW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'(int'(idx) * 4);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
  endtask

  task automatic apply_settings(input pid_cfg_t c);
    apb_write(REG_PROP_GAIN, {8'h00, c.kp});
    apb_write(REG_INTEG_GAIN, {8'h00, c.ki});
    apb_write(REG_DERIV_GAIN, {8'h00, c.kd});
    apb_write(REG_INTEG_LIMIT, {1'b0, c.ilim});
    apb_write(REG_OUT_LIMIT, {1'b0, c.olim});
    apb_write(REG_INTEG_BAND, {16'h0000, c.band});
    apb_write(REG_DEAD_ZONE, {16'h0000, c.dz});
    apb_write(REG_CTRL_MODE, {30'd0, c.mode});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    settings = c;
    settings_count++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_word(input logic signed [SampleW-1:0] sp,
                           input logic signed [SampleW-1:0] ms,
                           input bit known, input pid_result_t typed);
    int gap;
    pid_result_t r;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.setpoint <= sp;
    in_ch.measurement <= ms;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    r = predict_tick(sp, ms);
    pending_drives.push_back(known ? typed : r);
    words_sent++;
  endtask

  function automatic pid_cfg_t group_settings(input int grp);
    pid_cfg_t c;
    case (grp)
      1: c = '{24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 31'h7fffffff, 31'(DirLim),
               16'hffff, 16'd50, ModePos};
      2: c = '{24'sh010000, 24'sh004000, 24'sh002000, 31'h04000000, 31'h7fffffff,
               16'd2000, 16'd0, ModeIncr};
      3: c = '{24'sh008000, 24'sh010000, 24'sh000000, 31'(20 * 65536), 31'(5 * 65536),
               16'hffff, 16'd0, ModeTrap};
      default: c = '{24'sh800000, 24'sh800000, 24'sh800000, 31'd0, 31'd0,
                     16'd0, 16'hffff, ModeIncrTrap};
    endcase
    return c;
  endfunction

  function automatic logic signed [GainW-1:0] rand_gain();
    case ($urandom_range(0, 7))
      0: return GainW'($urandom);
      1: return 24'sh7fffff;
      2: return 24'sh800000;
      3: return '0;
      default: return GainW'($urandom_range(0, 262143)) - 24'sd131072;
    endcase
  endfunction

  function automatic logic [LimW-1:0] rand_limit();
    case ($urandom_range(0, 5))
      0: return 31'h7fffffff;
      1: return '0;
      2: return LimW'($urandom);
      default: return LimW'($urandom_range(1, 2000) * 65536);
    endcase
  endfunction

  function automatic pid_cfg_t random_settings(input logic [ModeW-1:0] mode);
    pid_cfg_t c;
    c.kp = rand_gain();
    c.ki = rand_gain();
    c.kd = rand_gain();
    c.ilim = rand_limit();
    c.olim = rand_limit();
    case ($urandom_range(0, 4))
      0: c.band = 16'hffff;
      1: c.band = '0;
      2: c.band = BandW'($urandom);
      default: c.band = BandW'($urandom_range(500, 6000));
    endcase
    case ($urandom_range(0, 9))
      0: c.dz = BandW'($urandom);
      1, 2, 3: c.dz = '0;
      default: c.dz = BandW'($urandom_range(0, 64));
    endcase
    c.mode = mode;
    return c;
  endfunction

  initial begin
    int gap;
    pid_result_t want;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
      words_checked++;
      dz_seen += int'(out_ch.in_dead_zone === 1'b1);
      sat_seen += int'(out_ch.saturated === 1'b1);
      if (pending_drives.size() == 0) begin
        flag_error($sformatf("result word with nothing pending, drive %0d", out_ch.drive));
      end else begin
        want = pending_drives.pop_front();
        if (out_ch.drive !== want.drive) begin
          flag_error($sformatf("drive got %0d expected %0d", out_ch.drive, want.drive));
        end
        if (out_ch.in_dead_zone !== want.dz) begin
          flag_error($sformatf("in_dead_zone got %b expected %b", out_ch.in_dead_zone,
                               want.dz));
        end
        if (out_ch.saturated !== want.sat) begin
          flag_error($sformatf("saturated got %b expected %b", out_ch.saturated, want.sat));
        end
      end
    end
  end

  initial begin
    int grp;
    int err_walk;
    int lo;
    int hi;
    int ms;
    pid_result_t typed;
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.setpoint <= '0;
    in_ch.measurement <= '0;
    quiet = 1'b0;
    settings = '{24'sh0, 24'sh0, 24'sh0, 31'h7fffffff, 31'h7fffffff, 16'hffff, 16'd0,
                 ModePos};
    last_err = 0;
    last_err2 = 0;
    integ_state = 0;
    out_state = 0;
    deriv_last = 0;
    deriv_last2 = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    grp = 0;
    foreach (dir_rows[i]) begin
      if (int'(dir_rows[i].group) != grp) begin
        drain_results();
        grp = int'(dir_rows[i].group);
        apply_settings(group_settings(grp));
      end
      typed.drive = dir_rows[i].drive;
      typed.dz = dir_rows[i].dz;
      typed.sat = dir_rows[i].sat;
      send_word(dir_rows[i].sp, dir_rows[i].ms, dir_rows[i].known, typed);
    end

    err_walk = 0;
    for (int ph = 0; ph < RandPhases; ph++) begin
      drain_results();
      apply_settings(random_settings(ModeW'(ph % 4)));
      quiet = (ph % 3 == 2);
      for (int n = 0; n < WordsPerPhase; n++) begin
        if ($urandom_range(0, 99) == 0) begin
          drain_results();
        end
        case ($urandom_range(0, 9))
          0: err_walk = int'($urandom_range(0, 131070)) - 65535;
          1: err_walk = int'($urandom_range(0, 12000)) - 6000;
          default: err_walk += int'($urandom_range(0, 200)) - 100;
        endcase
        if (err_walk > 65535) begin
          err_walk = 65535;
        end else if (err_walk < -65535) begin
          err_walk = -65535;
        end
        lo = (-32768 - err_walk > -32768) ? -32768 - err_walk : -32768;
        hi = (32767 - err_walk < 32767) ? 32767 - err_walk : 32767;
        ms = lo + int'($urandom_range(0, hi - lo));
        send_word(SampleW'(ms + err_walk), SampleW'(ms), 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d control ticks under %0d register settings, checked %0d results.",
             words_sent, settings_count + 1, words_checked);
    $display("Results in the dead zone: %0d, results at the output clamp: %0d.",
             dz_seen, sat_seen);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pcd_pkg.sv
hw/rtl/pcd_ifs.sv
hw/rtl/pid_controller_pos_delta_top.sv
verif/pid_controller_pos_delta_top_test.sv
